>>> hw/rtl/atrd_pkg.sv
// ----------------------------------------------------------------------------
// atrd_pkg: shared types and constants of the alpha text RLE decoder
// Widths, level codes, register indexes, state encodings and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package atrd_pkg;

	localparam int COORD_BITS    = 16;
	localparam int LEVEL_BITS    = 8;
	localparam int COLOR_BITS    = 8;
	localparam int BPL_BITS      = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int DIV_BITS      = 16;
	localparam int DIV_CNT_BITS  = 4;

	localparam logic [LEVEL_BITS-1:0] ESCAPE_LEVEL = 8'h1f;
	localparam logic [LEVEL_BITS-1:0] FULL_ALPHA   = 8'hff;
	localparam logic [LEVEL_BITS-1:0] EMPTY_LEVEL  = 8'h00;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_BPL    = 3'd2,
		CFG_RED    = 3'd3,
		CFG_GREEN  = 3'd4,
		CFG_BLUE   = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		PH_LEVEL = 5'b00001,
		PH_COUNT = 5'b00010,
		PH_RED   = 5'b00100,
		PH_GREEN = 5'b01000,
		PH_BLUE  = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic emit;
	} atrd_cmd_t;

	typedef struct packed {
		logic has_run;
		logic div_done;
		logic out_free;
	} atrd_stat_t;

endpackage

>>> hw/rtl/atrd_if.sv
// ----------------------------------------------------------------------------
// atrd_if: stream channels of the alpha text RLE decoder
// Coded byte channel in, run channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface atrd_in_if import atrd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] code_byte;
	logic                  start_image;

	modport source(output valid, code_byte, start_image, input ready);
	modport sink(input valid, code_byte, start_image, output ready);
endinterface

interface atrd_out_if import atrd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [COORD_BITS-1:0] run_length;
	logic [COLOR_BITS-1:0] alpha;
	logic [COLOR_BITS-1:0] red;
	logic [COLOR_BITS-1:0] green;
	logic [COLOR_BITS-1:0] blue;
	logic                  image_done;

	modport source(output valid, pos_x, pos_y, run_length, alpha, red, green, blue,
		image_done, input ready);
	modport sink(input valid, pos_x, pos_y, run_length, alpha, red, green, blue,
		image_done, output ready);
endinterface

>>> hw/rtl/alpha_text_rle_decoder.sv
// ----------------------------------------------------------------------------
// alpha_text_rle_decoder: run-length decoder for anti-aliased text bitmaps
// Usage:
//   codes carries one coded byte per beat; start_image on a beat clears the
//   position and reloads the color from fore_red/green/blue before decoding.
//   runs carries one run per beat: position, length, alpha, color and a flag
//   on the run that completes the last row. Configuration registers (width,
//   height, bits per level, fore color) are written through cfg_we/cfg_index/
//   cfg_data; the user must do so only while no byte is in flight (unchecked).
// Timing:
//   A byte that yields no run (color escape, color byte, level awaiting its
//   count, zero count after a maximum level, ignored byte) leaves ready
//   high. A byte that yields a run starts the bit-serial alpha divider
//   (level*255/max); its done flag moves the controller to its emit state,
//   which loads the output register once it is free. ready stays low from
//   the accept until the run is loaded, so the next byte waits for that.
//   Reset returns the decoder to expect a level byte with position and
//   color cleared and the registers at their defaults.
//   A stalled receiver holds the run in the output register; bytes without a
//   run keep being taken, and the next run waits until the register frees.
// ----------------------------------------------------------------------------
module alpha_text_rle_decoder import atrd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	atrd_in_if.sink                  codes,
	atrd_out_if.source               runs
);

	atrd_cmd_t  cmd;
	atrd_stat_t stat;
	logic       in_ready;

	atrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (codes.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	atrd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.code_byte   (codes.code_byte),
		.start_image (codes.start_image),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (runs.ready),
		.out_valid   (runs.valid),
		.pos_x       (runs.pos_x),
		.pos_y       (runs.pos_y),
		.run_length  (runs.run_length),
		.alpha       (runs.alpha),
		.red         (runs.red),
		.green       (runs.green),
		.blue        (runs.blue),
		.image_done  (runs.image_done)
	);

	assign codes.ready = in_ready;

endmodule

>>> hw/rtl/atrd_div.sv
// ----------------------------------------------------------------------------
// atrd_div: serial restoring divider
// One quotient bit per cycle; done is registered with the last bit and is high for a single cycle.
// ----------------------------------------------------------------------------
module atrd_div import atrd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0] divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quotient
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0]     num_q;
	logic [DIV_BITS-1:0]     rem_q;
	logic [DIV_BITS-1:0]     dvs_q;
	logic [DIV_BITS:0]       trial;
	logic [DIV_BITS:0]       diff;
	logic                    ge;

	always_comb begin
		trial = {rem_q, num_q[DIV_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_BITS'(1);
			if (cnt_q == DIV_CNT_BITS'(DIV_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
			num_q <= {num_q[DIV_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

>>> hw/rtl/atrd_dp.sv
// ----------------------------------------------------------------------------
// atrd_dp: datapath of the alpha text RLE decoder
// Configuration registers, decode phase, position and color state,
// byte decode, alpha divider and the output register.
// ----------------------------------------------------------------------------
module atrd_dp import atrd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic [LEVEL_BITS-1:0]    code_byte,
	input  logic                     start_image,
	input  atrd_cmd_t                cmd,
	output atrd_stat_t               stat,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [COORD_BITS-1:0]    pos_x,
	output logic [COORD_BITS-1:0]    pos_y,
	output logic [COORD_BITS-1:0]    run_length,
	output logic [COLOR_BITS-1:0]    alpha,
	output logic [COLOR_BITS-1:0]    red,
	output logic [COLOR_BITS-1:0]    green,
	output logic [COLOR_BITS-1:0]    blue,
	output logic                     image_done
);

	logic [COORD_BITS-1:0] width_q;
	logic [COORD_BITS-1:0] height_q;
	logic [BPL_BITS-1:0]   bpl_q;
	logic [COLOR_BITS-1:0] fore_red_q;
	logic [COLOR_BITS-1:0] fore_green_q;
	logic [COLOR_BITS-1:0] fore_blue_q;

	phase_t                phase_q;
	logic [LEVEL_BITS-1:0] held_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [COLOR_BITS-1:0] red_q;
	logic [COLOR_BITS-1:0] green_q;
	logic [COLOR_BITS-1:0] blue_q;
	logic                  fin_q;
	logic [COORD_BITS-1:0] pend_len_q;
	logic                  out_valid_q;

	logic [COORD_BITS-1:0] width_eff;
	logic [BPL_BITS-1:0]   bpl_eff;
	logic [DIV_BITS-1:0]   level_max;
	phase_t                eff_phase;
	logic [COORD_BITS-1:0] eff_col;
	logic [COORD_BITS-1:0] eff_row;
	logic [COLOR_BITS-1:0] eff_red;
	logic [COLOR_BITS-1:0] eff_green;
	logic [COLOR_BITS-1:0] eff_blue;
	logic                  eff_fin;
	logic                  skip;
	logic [COORD_BITS-1:0] rem;
	logic [COORD_BITS-1:0] byte_ext;
	phase_t                nxt_phase;
	logic [LEVEL_BITS-1:0] nxt_held;
	logic [COLOR_BITS-1:0] nxt_red;
	logic [COLOR_BITS-1:0] nxt_green;
	logic [COLOR_BITS-1:0] nxt_blue;
	logic                  has_run;
	logic [COORD_BITS-1:0] run_len;
	logic [LEVEL_BITS-1:0] run_level;
	logic [DIV_BITS-1:0]   dividend;
	logic                  div_done;
	logic [DIV_BITS-1:0]   quot;
	logic [COORD_BITS:0]   col_sum;
	logic [COORD_BITS:0]   row_inc;
	logic                  row_end;
	logic                  last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= COORD_BITS'(1);
			height_q     <= '0;
			bpl_q        <= BPL_BITS'(8);
			fore_red_q   <= '0;
			fore_green_q <= '0;
			fore_blue_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  width_q      <= cfg_data[COORD_BITS-1:0];
				CFG_HEIGHT: height_q     <= cfg_data[COORD_BITS-1:0];
				CFG_BPL:    bpl_q        <= cfg_data[BPL_BITS-1:0];
				CFG_RED:    fore_red_q   <= cfg_data[COLOR_BITS-1:0];
				CFG_GREEN:  fore_green_q <= cfg_data[COLOR_BITS-1:0];
				CFG_BLUE:   fore_blue_q  <= cfg_data[COLOR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		width_eff = (width_q == '0) ? COORD_BITS'(1) : width_q;
		bpl_eff   = (bpl_q == '0) ? BPL_BITS'(1) : bpl_q;
		level_max = (DIV_BITS'(1) << bpl_eff) - DIV_BITS'(1);

		eff_phase = start_image ? PH_LEVEL : phase_q;
		eff_col   = start_image ? '0 : col_q;
		eff_row   = start_image ? '0 : row_q;
		eff_fin   = start_image ? 1'b0 : fin_q;
		eff_red   = start_image ? fore_red_q : red_q;
		eff_green = start_image ? fore_green_q : green_q;
		eff_blue  = start_image ? fore_blue_q : blue_q;

		skip     = eff_fin || (eff_row >= height_q);
		rem      = (eff_col < width_eff) ? (width_eff - eff_col) : COORD_BITS'(1);
		byte_ext = COORD_BITS'(code_byte);

		nxt_phase = eff_phase;
		nxt_held  = held_q;
		nxt_red   = eff_red;
		nxt_green = eff_green;
		nxt_blue  = eff_blue;
		has_run   = 1'b0;
		run_len   = COORD_BITS'(1);
		run_level = code_byte;

		if (!skip) begin
			case (eff_phase)
				PH_RED: begin
					nxt_red   = code_byte;
					nxt_phase = PH_GREEN;
				end
				PH_GREEN: begin
					nxt_green = code_byte;
					nxt_phase = PH_BLUE;
				end
				PH_BLUE: begin
					nxt_blue  = code_byte;
					nxt_phase = PH_LEVEL;
				end
				PH_COUNT: begin
					nxt_phase = PH_LEVEL;
					run_level = held_q;
					if (code_byte == EMPTY_LEVEL) begin
						has_run = (held_q == EMPTY_LEVEL);
						run_len = rem;
					end else begin
						has_run = 1'b1;
						run_len = (byte_ext < rem) ? byte_ext : rem;
					end
				end
				default: begin
					nxt_phase = PH_LEVEL;
					if (code_byte == ESCAPE_LEVEL) begin
						nxt_phase = PH_RED;
					end else if (code_byte == EMPTY_LEVEL ||
						DIV_BITS'(code_byte) == level_max) begin
						nxt_held  = code_byte;
						nxt_phase = PH_COUNT;
					end else begin
						has_run = 1'b1;
					end
				end
			endcase
		end

		dividend = DIV_BITS'(run_level) * DIV_BITS'(FULL_ALPHA);

		col_sum  = {1'b0, col_q} + {1'b0, pend_len_q};
		row_inc  = {1'b0, row_q} + (COORD_BITS + 1)'(1);
		row_end  = col_sum >= {1'b0, width_eff};
		last_row = row_end && (row_inc >= {1'b0, height_q});
	end

	atrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (level_max),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEVEL;
			held_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			fin_q   <= 1'b0;
		end else if (cmd.accept) begin
			phase_q <= nxt_phase;
			held_q  <= nxt_held;
			red_q   <= nxt_red;
			green_q <= nxt_green;
			blue_q  <= nxt_blue;
			col_q   <= eff_col;
			row_q   <= eff_row;
			fin_q   <= eff_fin;
		end else if (cmd.emit) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= row_inc[COORD_BITS-1:0];
				if (last_row) begin
					fin_q <= 1'b1;
				end
			end else begin
				col_q <= col_sum[COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_len_q <= run_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pos_x      <= col_q;
			pos_y      <= row_q;
			run_length <= pend_len_q;
			alpha      <= quot[COLOR_BITS-1:0];
			red        <= red_q;
			green      <= green_q;
			blue       <= blue_q;
			image_done <= last_row;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.has_run  = has_run;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

>>> hw/rtl/atrd_ctrl.sv
// ----------------------------------------------------------------------------
// atrd_ctrl: controller of the alpha text RLE decoder
// Takes a byte, waits on the alpha divider for a run, then hands the run
// to the output register once it is free.
// ----------------------------------------------------------------------------
module atrd_ctrl import atrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  atrd_stat_t stat,
	output atrd_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd.accept    = in_ready && in_valid;
		cmd.div_start = cmd.accept && stat.has_run;
		cmd.emit      = (state_q == ST_EMIT) && stat.out_free;

		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.div_start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/atrd_checker.sv
// ----------------------------------------------------------------------------
// atrd_checker: port-level checks of the alpha text RLE decoder
// Output handshake rules and run timing seen at the top-level ports.
// ----------------------------------------------------------------------------
module atrd_checker import atrd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] pos_x,
	input logic [COORD_BITS-1:0] pos_y,
	input logic [COORD_BITS-1:0] run_length,
	input logic [COLOR_BITS-1:0] alpha,
	input logic [COLOR_BITS-1:0] red,
	input logic [COLOR_BITS-1:0] green,
	input logic [COLOR_BITS-1:0] blue,
	input logic                  image_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("run dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y) &&
		$stable(run_length) && $stable(alpha) && $stable(red) &&
		$stable(green) && $stable(blue) && $stable(image_done))
		else $error("run payload changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("empty run emitted");

	a_run_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready) && !$past(in_valid && in_ready))
		else $error("run loaded while byte channel was open");

endmodule

bind alpha_text_rle_decoder atrd_checker u_atrd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (codes.valid),
	.in_ready   (codes.ready),
	.out_valid  (runs.valid),
	.out_ready  (runs.ready),
	.pos_x      (runs.pos_x),
	.pos_y      (runs.pos_y),
	.run_length (runs.run_length),
	.alpha      (runs.alpha),
	.red        (runs.red),
	.green      (runs.green),
	.blue       (runs.blue),
	.image_done (runs.image_done)
);
